@@ hw/rtl/srpf_pkg.sv @@
package srpf_pkg;

    // Pixel and register widths
    localparam int PIX_W     = 8;
    localparam int MIN_RUN_W = 7;
    localparam int CFG_W     = 7;

    // Defaults for the top level parameters
    localparam int MAX_RUN_DEF   = 64;
    localparam int CMD_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST  = 7'd30;
    localparam logic                 POLARITY_RST = 1'b0;

    // Values written over a cleared run
    localparam logic [PIX_W-1:0] FILL_HI = 8'hFF;
    localparam logic [PIX_W-1:0] FILL_LO = 8'h00;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MIN_RUN  = 1'b0,
        CFG_POLARITY = 1'b1
    } t_cfg_idx;

    // Control part of one command from the front to the back
    typedef struct packed {
        logic wr;       // store the pixel in the run buffer
        logic keep;     // flushed pixels go out unchanged, else as fill
        logic fill_hi;  // fill value is 255, else 0
        logic emit;     // pixel goes out after the flush
        logic done;     // emitted pixel closes the line
    } t_cmd_ctl;

endpackage

@@ hw/rtl/srpf_stream_if.sv @@
// Input pixel channel
interface srpf_in_if;
    logic                      valid;
    logic                      ready;
    logic [srpf_pkg::PIX_W-1:0] pixel_in;
    logic                      line_first;
    logic                      line_last;

    modport source (output valid, output pixel_in, output line_first, output line_last,
                    input ready);
    modport sink   (input valid, input pixel_in, input line_first, input line_last,
                    output ready);
endinterface

// Output pixel channel
interface srpf_out_if;
    logic                      valid;
    logic                      ready;
    logic [srpf_pkg::PIX_W-1:0] pixel_out;
    logic                      burst_last;
    logic                      line_done;

    modport source (output valid, output pixel_out, output burst_last, output line_done,
                    input ready);
    modport sink   (input valid, input pixel_out, input burst_last, input line_done,
                    output ready);
endinterface

@@ hw/rtl/short_run_pixel_filter.sv @@
// Path: an item passes through the command queue, the back-end sequencer, the
// read stage and the output register.
// Throughput: in the back end a passed pixel takes a command pop and then an emit,
// a held pixel a pop only, and a released run one pixel per cycle; the back end
// reads one run-buffer entry per cycle while the read stage can take it.
// Reset: synchronous, active low; clears run state, command queue and output
// valid, loads min_run 30 and polarity 0. The run buffer is not cleared.
module short_run_pixel_filter #(
    parameter int MAX_RUN   = srpf_pkg::MAX_RUN_DEF,
    parameter int CMD_DEPTH = srpf_pkg::CMD_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  srpf_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [srpf_pkg::CFG_W-1:0] i_cfg_data,
    srpf_in_if.sink                    i_in,
    srpf_out_if.source                 o_out
);

    localparam int AW = $clog2(MAX_RUN);
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int QW = $bits(srpf_pkg::t_cmd_ctl) + srpf_pkg::PIX_W + AW + CW;

    logic                       cmd_push, cmd_pop, cmd_full, cmd_empty;
    srpf_pkg::t_cmd_ctl         push_ctl, pop_ctl;
    logic [srpf_pkg::PIX_W-1:0] push_pix, pop_pix;
    logic [AW-1:0]              push_idx, pop_idx;
    logic [CW-1:0]              push_cnt, pop_cnt;
    logic [QW-1:0]              push_data, pop_data;

    // Front: register file, run tracking, command build
    srpf_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd_ctl  (push_ctl),
        .o_cmd_pix  (push_pix),
        .o_cmd_idx  (push_idx),
        .o_cmd_cnt  (push_cnt)
    );

    assign push_data = {push_ctl, push_pix, push_idx, push_cnt};
    assign {pop_ctl, pop_pix, pop_idx, pop_cnt} = pop_data;

    // Command queue between front and back
    srpf_cmd_fifo #(
        .W     (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (push_data),
        .i_pop   (cmd_pop),
        .o_data  (pop_data),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    // Back: run buffer, flush sequencer, output register
    srpf_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_ctl   (pop_ctl),
        .i_cmd_pix   (pop_pix),
        .i_cmd_idx   (pop_idx),
        .i_cmd_cnt   (pop_cnt),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

`ifndef SYNTH
    // A run released on reaching the threshold includes the pixel just stored
    a_release_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_push && push_ctl.wr && push_cnt != '0) |-> (push_cnt == CW'(push_idx) + CW'(1)))
        else $error("released run length does not match the stored pixel");

    // A command that neither stores nor emits would lose its pixel
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> (push_ctl.wr || push_ctl.emit))
        else $error("command drops its pixel");

    // Held pixels flushed without an emit must come from the storing command
    a_flush_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && !pop_ctl.emit && pop_cnt != '0) |-> (pop_ctl.wr && pop_ctl.keep))
        else $error("flush without emit is not a threshold release");

    // The queue is never popped while empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_empty |-> !cmd_pop)
        else $error("command queue popped while empty");
`endif

endmodule

@@ hw/rtl/srpf_front.sv @@
module srpf_front #(
    parameter int MAX_RUN = srpf_pkg::MAX_RUN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  srpf_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [srpf_pkg::CFG_W-1:0]    i_cfg_data,
    srpf_in_if.sink                       i_in,
    input  logic                          i_cmd_full,
    output logic                          o_cmd_push,
    output srpf_pkg::t_cmd_ctl            o_cmd_ctl,
    output logic [srpf_pkg::PIX_W-1:0]    o_cmd_pix,
    output logic [$clog2(MAX_RUN)-1:0]    o_cmd_idx,
    output logic [$clog2(MAX_RUN+1)-1:0]  o_cmd_cnt
);

    localparam int AW = $clog2(MAX_RUN);
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int TW = (CW > srpf_pkg::MIN_RUN_W) ? CW : srpf_pkg::MIN_RUN_W;

    logic [srpf_pkg::MIN_RUN_W-1:0] r_min_run;
    logic                           r_polarity;
    logic [CW-1:0]                  r_len, n_len;
    logic                           r_conf, n_conf;

    logic          active;
    logic [TW-1:0] thr;
    logic [CW-1:0] len_inc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run  <= srpf_pkg::MIN_RUN_RST;
            r_polarity <= srpf_pkg::POLARITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srpf_pkg::CFG_MIN_RUN:  r_min_run  <= i_cfg_data[srpf_pkg::MIN_RUN_W-1:0];
                srpf_pkg::CFG_POLARITY: r_polarity <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective threshold, clamped to 1..MAX_RUN
    always_comb begin
        if (r_min_run == '0) begin
            thr = TW'(1);
        end else if (TW'(r_min_run) > TW'(MAX_RUN)) begin
            thr = TW'(MAX_RUN);
        end else begin
            thr = TW'(r_min_run);
        end
    end

    assign active  = r_polarity ? (i_in.pixel_in == '0) : (i_in.pixel_in != '0);
    assign len_inc = r_len + CW'(1);

    assign i_in.ready = !i_cmd_full;
    assign o_cmd_push = i_in.valid && !i_cmd_full;
    assign o_cmd_pix  = i_in.pixel_in;
    assign o_cmd_idx  = r_len[AW-1:0];

    // Classify the pixel and build the command
    always_comb begin
        o_cmd_ctl         = '0;
        o_cmd_ctl.fill_hi = r_polarity;
        o_cmd_cnt         = r_len;
        n_len             = r_len;
        n_conf            = r_conf;
        if (i_in.line_first) begin
            // line start: held pixels go out unchanged
            o_cmd_ctl.keep = 1'b1;
            o_cmd_ctl.emit = 1'b1;
            o_cmd_ctl.done = i_in.line_last;
            n_len          = '0;
            n_conf         = 1'b0;
        end else if (i_in.line_last) begin
            // run reaching the border is kept
            o_cmd_ctl.keep = active;
            o_cmd_ctl.emit = 1'b1;
            o_cmd_ctl.done = 1'b1;
            n_len          = '0;
            n_conf         = 1'b0;
        end else if (!active) begin
            // short run ended: cleared to fill
            o_cmd_ctl.emit = 1'b1;
            n_len          = '0;
            n_conf         = 1'b0;
        end else if (r_conf) begin
            o_cmd_ctl.emit = 1'b1;
            o_cmd_cnt      = '0;
        end else begin
            // hold the pixel; release the whole run once it is long enough
            o_cmd_ctl.wr = 1'b1;
            if (TW'(len_inc) >= thr) begin
                o_cmd_ctl.keep = 1'b1;
                o_cmd_cnt      = len_inc;
                n_len          = '0;
                n_conf         = 1'b1;
            end else begin
                o_cmd_cnt = '0;
                n_len     = len_inc;
            end
        end
    end

    // Run tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_conf <= 1'b0;
        end else if (o_cmd_push) begin
            r_len  <= n_len;
            r_conf <= n_conf;
        end
    end

endmodule

@@ hw/rtl/srpf_cmd_fifo.sv @@
module srpf_cmd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = srpf_pkg::CMD_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/srpf_back.sv @@
module srpf_back #(
    parameter int MAX_RUN = srpf_pkg::MAX_RUN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_empty,
    input  srpf_pkg::t_cmd_ctl            i_cmd_ctl,
    input  logic [srpf_pkg::PIX_W-1:0]    i_cmd_pix,
    input  logic [$clog2(MAX_RUN)-1:0]    i_cmd_idx,
    input  logic [$clog2(MAX_RUN+1)-1:0]  i_cmd_cnt,
    output logic                          o_cmd_pop,
    srpf_out_if.source                    o_out
);

    localparam int AW = $clog2(MAX_RUN);
    localparam int CW = $clog2(MAX_RUN + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_PIX   = 3'b100
    } t_state;

    // Sequencer
    t_state                     r_state, n_state;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_end, n_end;
    logic                       r_keep, n_keep;
    logic                       r_fill_hi, n_fill_hi;
    logic                       r_emit, n_emit;
    logic                       r_done, n_done;
    logic [srpf_pkg::PIX_W-1:0] r_pix, n_pix;

    // Run buffer
    logic [srpf_pkg::PIX_W-1:0] r_buf [MAX_RUN];
    logic [srpf_pkg::PIX_W-1:0] r_rd_data;
    logic                       rd_en, wr_en;

    // Read stage
    logic                       r_s1_v;
    logic                       r_s1_mem, r_s1_keep, r_s1_fill_hi, r_s1_last, r_s1_done;
    logic [srpf_pkg::PIX_W-1:0] r_s1_pix;
    logic                       s1_load, s1_mem, s1_last, s1_done;
    logic                       s1_free, s1_move;
    logic [srpf_pkg::PIX_W-1:0] s1_value;

    // Output stage
    logic                       r_o_v;
    logic [srpf_pkg::PIX_W-1:0] r_o_pix;
    logic                       r_o_last, r_o_done;

    assign s1_move = r_s1_v && (!r_o_v || o_out.ready);
    assign s1_free = !r_s1_v || s1_move;
    assign wr_en   = o_cmd_pop && i_cmd_ctl.wr;

    // Command sequencing: pop, flush held pixels, then the pixel itself
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_end     = r_end;
        n_keep    = r_keep;
        n_fill_hi = r_fill_hi;
        n_emit    = r_emit;
        n_done    = r_done;
        n_pix     = r_pix;
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        s1_load   = 1'b0;
        s1_mem    = 1'b0;
        s1_last   = 1'b0;
        s1_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_idx     = '0;
                    n_end     = AW'(i_cmd_cnt - CW'(1));
                    n_keep    = i_cmd_ctl.keep;
                    n_fill_hi = i_cmd_ctl.fill_hi;
                    n_emit    = i_cmd_ctl.emit;
                    n_done    = i_cmd_ctl.done;
                    n_pix     = i_cmd_pix;
                    if (i_cmd_cnt != '0) begin
                        n_state = S_FLUSH;
                    end else if (i_cmd_ctl.emit) begin
                        n_state = S_PIX;
                    end
                end
            end
            S_FLUSH: begin
                if (s1_free) begin
                    rd_en   = 1'b1;
                    s1_load = 1'b1;
                    s1_mem  = 1'b1;
                    s1_last = (r_idx == r_end) && !r_emit;
                    n_idx   = r_idx + AW'(1);
                    if (r_idx == r_end) begin
                        n_state = r_emit ? S_PIX : S_IDLE;
                    end
                end
            end
            S_PIX: begin
                if (s1_free) begin
                    s1_load = 1'b1;
                    s1_last = 1'b1;
                    s1_done = r_done;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_keep    <= n_keep;
        r_fill_hi <= n_fill_hi;
        r_emit    <= n_emit;
        r_done    <= n_done;
        r_pix     <= n_pix;
    end

    // Run buffer: write on the pop of a storing command, registered read while flushing
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[i_cmd_idx] <= i_cmd_pix;
        end
        if (rd_en) begin
            r_rd_data <= r_buf[r_idx];
        end
    end

    // Read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_load) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_mem     <= s1_mem;
            r_s1_keep    <= r_keep;
            r_s1_fill_hi <= r_fill_hi;
            r_s1_pix     <= r_pix;
            r_s1_last    <= s1_last;
            r_s1_done    <= s1_done;
        end
    end

    // Held pixel unchanged or replaced by the fill value
    always_comb begin
        if (!r_s1_mem) begin
            s1_value = r_s1_pix;
        end else if (r_s1_keep) begin
            s1_value = r_rd_data;
        end else begin
            s1_value = r_s1_fill_hi ? srpf_pkg::FILL_HI : srpf_pkg::FILL_LO;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_move) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_pix  <= s1_value;
            r_o_last <= r_s1_last;
            r_o_done <= r_s1_done;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.pixel_out  = r_o_pix;
    assign o_out.burst_last = r_o_last;
    assign o_out.line_done  = r_o_done;

endmodule

@@ dv/short_run_pixel_filter_test.sv @@
`timescale 1ns / 100ps

module short_run_pixel_filter_test;

    localparam int MAX_RUN     = srpf_pkg::MAX_RUN_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 12;

    // One filtered pixel as it should leave the block
    typedef struct packed {
        logic [srpf_pkg::PIX_W-1:0] pixel;
        logic                       burst_last;
        logic                       line_done;
    } t_px_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    srpf_pkg::t_cfg_idx         i_cfg_idx;
    logic [srpf_pkg::CFG_W-1:0] i_cfg_data;

    srpf_in_if  in_if();
    srpf_out_if out_if();

    short_run_pixel_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Filter model state
    logic [srpf_pkg::PIX_W-1:0]     held_px [MAX_RUN];
    int                             held_cnt;
    logic                           run_ok;
    logic [srpf_pkg::MIN_RUN_W-1:0] mdl_min_run;
    logic                           mdl_polarity;
    t_px_result                     filt_q[$];

    // Traffic shaping and bookkeeping
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_off;
    int cycle_count;
    int items_sent;
    int results_seen;
    int cfg_writes;
    int mismatch_count;
    t_px_result got_px;
    t_px_result want_px;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[short_run_pixel_filter] ERROR");
        $finish;
    end

    // Output ready: long hold-off first, else random stall
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                out_if.ready <= 1'b0;
                hold_off--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int eff_threshold();
        int thr;
        thr = int'(mdl_min_run);
        if (thr == 0) thr = 1;
        if (thr > MAX_RUN) thr = MAX_RUN;
        return thr;
    endfunction

    function automatic void queue_px(input logic [srpf_pkg::PIX_W-1:0] px, input logic done);
        t_px_result r;
        r.pixel      = px;
        r.burst_last = 1'b0;
        r.line_done  = done;
        filt_q.insert(filt_q.size(), r);
    endfunction

    // Release the pending run, unchanged or as fill
    function automatic void release_run(input logic keep,
                                        input logic [srpf_pkg::PIX_W-1:0] fill);
        for (int i = 0; i < held_cnt; i++)
            queue_px(keep ? held_px[i] : fill, 1'b0);
        held_cnt = 0;
        run_ok   = 1'b0;
    endfunction

    // Expected results of one accepted pixel
    function automatic void predict_pixel(input logic [srpf_pkg::PIX_W-1:0] px,
                                          input logic is_first, input logic is_last);
        logic                       act;
        logic [srpf_pkg::PIX_W-1:0] fill;
        int                         thr;
        int                         n0;
        act  = mdl_polarity ? (px == '0) : (px != '0);
        fill = mdl_polarity ? srpf_pkg::FILL_HI : srpf_pkg::FILL_LO;
        thr  = eff_threshold();
        n0   = filt_q.size();
        if (is_first) begin
            release_run(1'b1, fill);
            queue_px(px, is_last);
        end else if (is_last) begin
            release_run(act, fill);
            queue_px(px, 1'b1);
        end else if (!act) begin
            release_run(1'b0, fill);
            queue_px(px, 1'b0);
        end else if (run_ok) begin
            queue_px(px, 1'b0);
        end else begin
            if (held_cnt < MAX_RUN) begin
                held_px[held_cnt] = px;
                held_cnt++;
            end
            if (held_cnt >= thr) begin
                release_run(1'b1, fill);
                run_ok = 1'b1;
            end
        end
        // mark the end of this item's burst
        if (filt_q.size() > n0)
            filt_q[filt_q.size() - 1].burst_last = 1'b1;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            got_px.pixel      = out_if.pixel_out;
            got_px.burst_last = out_if.burst_last;
            got_px.line_done  = out_if.line_done;
            if (filt_q.size() == 0) begin
                report_mismatch("unexpected transfer", int'(got_px), 0);
            end else begin
                want_px = filt_q.pop_front();
                if (got_px.pixel != want_px.pixel)
                    report_mismatch("pixel_out", int'(got_px.pixel), int'(want_px.pixel));
                if (got_px.burst_last != want_px.burst_last)
                    report_mismatch("burst_last", int'(got_px.burst_last),
                                    int'(want_px.burst_last));
                if (got_px.line_done != want_px.line_done)
                    report_mismatch("line_done", int'(got_px.line_done),
                                    int'(want_px.line_done));
            end
        end
    end

    // One input transfer, with optional idle cycles ahead of it
    task automatic send_pixel(input logic [srpf_pkg::PIX_W-1:0] px, input logic is_first,
                              input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.pixel_in   <= px;
        in_if.line_first <= is_first;
        in_if.line_last  <= is_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_pixel(px, is_first, is_last);
        items_sent++;
    endtask

    // Stop sending, let every expected result arrive, then settle
    task automatic wait_drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (filt_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input srpf_pkg::t_cfg_idx idx,
                             input logic [srpf_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == srpf_pkg::CFG_MIN_RUN) mdl_min_run = val[srpf_pkg::MIN_RUN_W-1:0];
        else mdl_polarity = val[0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_filter(input int min_run, input logic pol);
        write_reg(srpf_pkg::CFG_MIN_RUN, min_run[srpf_pkg::CFG_W-1:0]);
        write_reg(srpf_pkg::CFG_POLARITY, {{(srpf_pkg::CFG_W-1){1'b0}}, pol});
    endtask

    // Short runs of nonzero pixels vanish; long runs, zeros and borders pass
    task automatic test_basic_runs();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_filter(3, 1'b0);
        send_pixel(8'h80, 1'b1, 1'b0);
        send_pixel(8'h05, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h07, 1'b0, 1'b0);
        send_pixel(8'h09, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hC8, 1'b0, 1'b0);
        send_pixel(8'hC9, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Run reaching the border, line start over a pending run,
    // single-pixel line, missing line start; sender often idle
    task automatic test_line_borders();
        tx_idle_pct  = 57;
        rx_stall_pct = 0;
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h2C, 1'b0, 1'b0);
        send_pixel(8'h2D, 1'b0, 1'b0);
        send_pixel(8'h2E, 1'b0, 1'b1);
        send_pixel(8'h21, 1'b1, 1'b0);
        send_pixel(8'h09, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b1, 1'b1);
        send_pixel(8'h33, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Polarity 1: short zero runs become 255; receiver often stalling
    task automatic test_fill_polarity();
        tx_idle_pct  = 0;
        rx_stall_pct = 57;
        set_filter(2, 1'b1);
        send_pixel(8'hFF, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h7F, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hFE, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Threshold lowered while a run is held; zero and oversize thresholds
    task automatic test_threshold_changes();
        tx_idle_pct  = 0;
        rx_stall_pct = 57;
        set_filter(5, 1'b0);
        send_pixel(8'h01, 1'b1, 1'b0);
        send_pixel(8'h32, 1'b0, 1'b0);
        send_pixel(8'h33, 1'b0, 1'b0);
        wait_drain();
        write_reg(srpf_pkg::CFG_MIN_RUN, 7'd2);
        send_pixel(8'h34, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
        wait_drain();
        write_reg(srpf_pkg::CFG_MIN_RUN, 7'd0);
        send_pixel(8'h03, 1'b1, 1'b0);
        send_pixel(8'h04, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
        wait_drain();
        write_reg(srpf_pkg::CFG_MIN_RUN, 7'd127);
        send_pixel(8'h03, 1'b1, 1'b0);
        send_pixel(8'h07, 1'b0, 1'b0);
        send_pixel(8'h08, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Threshold at its top: a 64-pixel run leaves as one burst; both sides idle
    task automatic test_longest_run();
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
        set_filter(MAX_RUN, 1'b0);
        send_pixel(8'h10, 1'b1, 1'b0);
        for (int k = 0; k < MAX_RUN; k++)
            send_pixel((k == MAX_RUN - 1) ? 8'hFF : 8'(k + 1), 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Receiver holds off while input keeps coming, then the sender pauses
    task automatic test_backpressure();
        set_filter(1, 1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        hold_off = 200;
        send_pixel(8'hA5, 1'b1, 1'b0);
        for (int k = 0; k < 9; k++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_pixel(8'h5A, 1'b0, 1'b1);
        wait_drain();
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h11, 1'b0, 1'b1);
        wait_drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = srpf_pkg::CFG_MIN_RUN;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.pixel_in   = '0;
        in_if.line_first = 1'b0;
        in_if.line_last  = 1'b0;
        out_if.ready     = 1'b0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        hold_off         = 0;
        items_sent       = 0;
        results_seen     = 0;
        cfg_writes       = 0;
        mismatch_count   = 0;
        held_cnt         = 0;
        run_ok           = 1'b0;
        mdl_min_run      = srpf_pkg::MIN_RUN_RST;
        mdl_polarity     = srpf_pkg::POLARITY_RST;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_basic_runs();
        test_line_borders();
        test_fill_polarity();
        test_threshold_changes();
        test_longest_run();
        test_backpressure();

        wait_drain();
        if (filt_q.size() != 0)
            report_mismatch("results never delivered", filt_q.size(), 0);
        $display("Covered short-run removal in both polarities, line borders, threshold");
        $display("changes, a full-length run and back-pressure: %0d pixels in, %0d out, %0d %s",
                 items_sent, results_seen, cfg_writes, "register writes.");
        if (mismatch_count == 0) begin
            $display("[short_run_pixel_filter] OK");
        end else begin
            $display("[short_run_pixel_filter] ERROR");
        end
        $finish;
    end

endmodule
